@@ hdl/lfutcd_pkg.sv @@
// ----------------------------------------------------------------------------
// lfutcd_pkg
// Shared widths, status codes and control structs of the LFU table directory.
// ----------------------------------------------------------------------------
package lfutcd_pkg;

  localparam int TagW    = 32;
  localparam int CntW    = 32;
  localparam int StatusW = 2;
  localparam int WayW    = 4;
  localparam int DefWays = 16;

  localparam logic [CntW-1:0] CntFull = '1;
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  typedef enum logic [StatusW-1:0] {
    ST_NONE = 2'd0,
    ST_HIT  = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic cmp;
    logic decide;
    logic refill;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic zero;
    logic hit;
    logic out_free;
  } ctrl_sts_t;

endpackage

@@ hdl/lfutcd_if.sv @@
// ----------------------------------------------------------------------------
// lfutcd_in_if / lfutcd_out_if
// Valid/ready channels for lookup requests and lookup results.
// ----------------------------------------------------------------------------
interface lfutcd_in_if
  import lfutcd_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [TagW-1:0] table_offset;

  modport source (output valid, output table_offset, input ready);
  modport sink   (input valid, input table_offset, output ready);
endinterface

interface lfutcd_out_if
  import lfutcd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [WayW-1:0]    way;

  modport source (output valid, output status, output way, input ready);
  modport sink   (input valid, input status, input way, output ready);
endinterface

@@ hdl/lfutcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfutcd_ctrl
// Sequencer: accept, tag compare, hit update or victim wait (neither on a zero offset), result push.
// ----------------------------------------------------------------------------
module lfutcd_ctrl
  import lfutcd_pkg::*;
#(
  parameter int WAYS = DefWays
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o,
  output logic      in_ready_o
);

  localparam int IdxW = $clog2(WAYS);
  localparam int WcW  = $clog2(IdxW + 2);
  localparam logic [WcW-1:0] WaitLast = WcW'(IdxW);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CMP    = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]     state_q, state_d;
  logic [WcW-1:0] wait_q, wait_d;

  always_comb begin
    state_d = state_q;
    wait_d  = wait_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (sts_i.in_valid) begin
          cmd_o.load = 1'b1;
          state_d    = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.zero || sts_i.hit) begin
          state_d = S_FINISH;
        end else begin
          wait_d  = '0;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (wait_q == WaitLast) begin
          cmd_o.refill = 1'b1;
          state_d      = S_FINISH;
        end else begin
          wait_d = wait_q + WcW'(1);
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wait_q  <= '0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

@@ hdl/lfutcd_dp.sv @@
// ----------------------------------------------------------------------------
// lfutcd_dp
// Tag and use-count lanes, parallel tag compare, registered minimum tree.
// ----------------------------------------------------------------------------
module lfutcd_dp
  import lfutcd_pkg::*;
#(
  parameter int WAYS = DefWays
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  input  logic [TagW-1:0]    table_offset_i,
  output logic               zero_o,
  output logic               hit_o,
  output logic [StatusW-1:0] res_status_o,
  output logic [WayW-1:0]    res_way_o
);

  localparam int IdxW  = $clog2(WAYS);
  localparam int Leaves = 1 << IdxW;
  localparam int Inner  = Leaves - 1;

  logic [TagW-1:0] tag_q;
  logic [TagW-1:0] tags_q [WAYS];
  logic [CntW-1:0] cnts_q [WAYS];

  logic [WAYS-1:0] match, near_full, lowest;
  logic [IdxW-1:0] match_idx;

  logic            zero_q, hit_q;
  logic [WAYS-1:0] hit_mask_q;
  logic [IdxW-1:0] hit_idx_q;
  logic            halve;

  logic [StatusW-1:0] res_status_q;
  logic [WayW-1:0]    res_way_q;

  // minimum tree, heap order; leaves combinational, inner nodes registered
  logic [CntW-1:0] leaf_cnt [Leaves];
  logic [IdxW-1:0] leaf_idx [Leaves];
  logic            leaf_vld [Leaves];
  logic [CntW-1:0] node_cnt [Inner];
  logic [IdxW-1:0] node_idx [Inner];
  logic            node_vld [Inner];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tag_q <= table_offset_i;
    end
  end

  always_comb begin
    match_idx = '0;
    for (int i = 0; i < WAYS; i++) begin
      match[i]     = (tags_q[i] == tag_q);
      near_full[i] = (cnts_q[i] == (CntFull - CntOne));
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_idx = IdxW'(i);
      end
    end
  end

  assign lowest = match & ~(match - WAYS'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      zero_q     <= (tag_q == '0);
      hit_q      <= |match;
      hit_mask_q <= lowest;
      hit_idx_q  <= match_idx;
    end
  end

  assign halve = cmd_i.decide && !zero_q && hit_q && |(hit_mask_q & near_full);

  for (genvar j = 0; j < WAYS; j++) begin : g_lane
    logic [CntW-1:0] inc;
    assign inc = cnts_q[j] + (hit_mask_q[j] ? CntOne : '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tags_q[j] <= '0;
        cnts_q[j] <= '0;
      end else if (cmd_i.refill && node_idx[0] == IdxW'(j)) begin
        tags_q[j] <= tag_q;
        cnts_q[j] <= CntOne;
      end else if (cmd_i.decide && !zero_q && hit_q) begin
        cnts_q[j] <= halve ? (inc >> 1) : inc;
      end
    end
  end

  for (genvar l = 0; l < Leaves; l++) begin : g_leaf
    if (l < WAYS) begin : g_real
      assign leaf_cnt[l] = cnts_q[l];
      assign leaf_vld[l] = 1'b1;
    end else begin : g_pad
      assign leaf_cnt[l] = CntFull;
      assign leaf_vld[l] = 1'b0;
    end
    assign leaf_idx[l] = IdxW'(l);
  end

  for (genvar n = 0; n < Inner; n++) begin : g_node
    logic [CntW-1:0] l_cnt, r_cnt;
    logic [IdxW-1:0] l_idx, r_idx;
    logic            l_vld, r_vld;
    logic            take_r;

    if (2 * n + 1 >= Inner) begin : g_from_leaf
      assign l_cnt = leaf_cnt[2*n+1-Inner];
      assign l_idx = leaf_idx[2*n+1-Inner];
      assign l_vld = leaf_vld[2*n+1-Inner];
      assign r_cnt = leaf_cnt[2*n+2-Inner];
      assign r_idx = leaf_idx[2*n+2-Inner];
      assign r_vld = leaf_vld[2*n+2-Inner];
    end else begin : g_from_node
      assign l_cnt = node_cnt[2*n+1];
      assign l_idx = node_idx[2*n+1];
      assign l_vld = node_vld[2*n+1];
      assign r_cnt = node_cnt[2*n+2];
      assign r_idx = node_idx[2*n+2];
      assign r_vld = node_vld[2*n+2];
    end

    assign take_r = r_vld && (r_cnt < l_cnt);

    always_ff @(posedge clk_i) begin
      node_cnt[n] <= take_r ? r_cnt : l_cnt;
      node_idx[n] <= take_r ? r_idx : l_idx;
      node_vld[n] <= l_vld || r_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      if (zero_q) begin
        res_status_q <= ST_NONE;
        res_way_q    <= '0;
      end else begin
        res_status_q <= ST_HIT;
        res_way_q    <= WayW'(hit_idx_q);
      end
    end else if (cmd_i.refill) begin
      res_status_q <= ST_MISS;
      res_way_q    <= WayW'(node_idx[0]);
    end
  end

  assign zero_o       = zero_q;
  assign hit_o        = hit_q;
  assign res_status_o = res_status_q;
  assign res_way_o    = res_way_q;

endmodule

@@ hdl/lfu_table_cache_directory.sv @@
// ----------------------------------------------------------------------------
// lfu_table_cache_directory
// LFU directory of a small fully associative cache of second-level tables.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request per table offset; out_o returns one result with
//   status (none / hit / miss-refilled) and the way that was hit or refilled.
//   A zero offset reports no table and leaves the directory untouched.
// Sequencing:
//   One request at a time. Zero offset or hit: after accept the result is
//   offered after compare, count update and push. Miss: the victim wait is
//   set by the depth of the registered minimum tree over the use counts,
//   which is drained before the victim is taken.
//   A new request is accepted as soon as the previous result is loaded into
//   the output register, even while that result still waits to be taken.
// Reset:
//   All tags and use counts clear to zero; no request pending, no result.
// Stall:
//   A result waits in the output register while out ready is low; a finished
//   next result waits in the block until the output register frees.
// ----------------------------------------------------------------------------
module lfu_table_cache_directory
  import lfutcd_pkg::*;
#(
  parameter int WAYS = DefWays
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lfutcd_in_if.sink    in_i,
  lfutcd_out_if.source out_o
);

  ctrl_cmd_t          cmd;
  ctrl_sts_t          sts;
  logic               zero, hit;
  logic [StatusW-1:0] res_status;
  logic [WayW-1:0]    res_way;

  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [WayW-1:0]    out_way_q;

  assign sts.in_valid = in_i.valid;
  assign sts.zero     = zero;
  assign sts.hit      = hit;
  assign sts.out_free = !out_valid_q || out_o.ready;

  lfutcd_ctrl #(.WAYS(WAYS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_i.ready)
  );

  lfutcd_dp #(.WAYS(WAYS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .table_offset_i (in_i.table_offset),
    .zero_o         (zero),
    .hit_o          (hit),
    .res_status_o   (res_status),
    .res_way_o      (res_way)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.push) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.push) begin
      out_status_q <= res_status;
      out_way_q    <= res_way;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.way    = out_way_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request accepted while previous one in flight");

  a_push_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (!out_valid_q || out_o.ready))
    else $error("result pushed over a pending result");

  a_none_way_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_NONE) |-> (out_o.way == '0))
    else $error("no-table result with nonzero way");
`endif

endmodule
